// ----- sv/fomw_pkg.sv -----
package fomw_pkg;

	// field widths
	localparam int ANGLE_BITS = 16;
	localparam int AXIS_BITS  = 16;
	localparam int GAIN_W     = 10;
	localparam int LIMIT_W    = 15;
	localparam int DRIVE_W    = 16;

	// CORDIC: Q2.30 data held in CW bits, 32-bit binary angle
	localparam int CORDIC_STEPS     = 30;
	localparam int CORDIC_PER_STAGE = 3;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int CW               = 34;
	localparam int ZW               = 32;
	localparam int TRIG_W           = 17;   // Q1.15 with room for +1.0
	localparam int TRIG_FRAC        = 15;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ZW-1:0] ROT_TABLE [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81,
		32'sd41,        32'sd20,        32'sd10,        32'sd5,
		32'sd3,         32'sd1
	};

	// mixer constants
	localparam int HW = 31;
	localparam logic signed [HW-1:0] HALF_SQRT2 = 31'sd759250125;   // 2^30 / sqrt 2
	localparam int TFW = 17;
	localparam logic signed [TFW-1:0] TURN_FACTOR = 17'sd65025;     // 4 * 63.75 * 255

	typedef struct packed {
		logic signed [AXIS_BITS-1:0] stick_x;
		logic signed [AXIS_BITS-1:0] stick_y;
		logic signed [AXIS_BITS-1:0] trigger_right;
		logic signed [AXIS_BITS-1:0] trigger_left;
	} axes_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_val;
		logic signed [TRIG_W-1:0] sin_val;
		axes_t                    axes;
	} trig_t;

endpackage

// ----- sv/fomw_if.sv -----
interface fomw_cmd_if import fomw_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [AXIS_BITS-1:0] stick_x;
	logic signed [AXIS_BITS-1:0] stick_y;
	logic signed [AXIS_BITS-1:0] trigger_right;
	logic signed [AXIS_BITS-1:0] trigger_left;
	logic [ANGLE_BITS-1:0]       heading;

	modport source (output valid, stick_x, stick_y, trigger_right, trigger_left, heading,
		input ready);
	modport sink (input valid, stick_x, stick_y, trigger_right, trigger_left, heading,
		output ready);
endinterface

interface fomw_drive_if import fomw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] wheel_one_drive;
	logic signed [DRIVE_W-1:0] wheel_two_drive;
	logic signed [DRIVE_W-1:0] wheel_three_drive;
	logic signed [DRIVE_W-1:0] wheel_four_drive;

	modport source (output valid, wheel_one_drive, wheel_two_drive, wheel_three_drive,
		wheel_four_drive, input ready);
	modport sink (input valid, wheel_one_drive, wheel_two_drive, wheel_three_drive,
		wheel_four_drive, output ready);
endinterface

// ----- sv/fomw_cordic.sv -----
module fomw_cordic import fomw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fomw_cmd_if.sink   cmd,
	output logic       trig_valid,
	input  logic       trig_ready,
	output trig_t      trig
);

	// fold stage, CORDIC_STAGES iteration stages, rounding stage
	localparam int NST = CORDIC_STAGES + 2;
	localparam logic signed [ZW-1:0] QUARTER = 32'sh4000_0000;

	function automatic logic signed [CW-1:0] div_pow2(input logic signed [CW-1:0] v,
		input int unsigned n);
		logic signed [CW-1:0] q;
		logic [CW-1:0]        low_mask;
		begin
			low_mask = ~({CW{1'b1}} << n);
			q = v >>> n;
			if (v[CW-1] && ((v & low_mask) != '0))
				q = q + CW'(1);
			return q;
		end
	endfunction

	function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v,
		input logic neg);
		logic [CW-1:0]     mag;
		logic [CW-1:0]     r;
		logic [TRIG_W-1:0] rc;
		begin
			mag = v[CW-1] ? CW'(-v) : CW'(v);
			r = (mag + (CW'(1) << (TRIG_FRAC - 1))) >> TRIG_FRAC;
			rc = (r > (CW'(1) << TRIG_FRAC)) ? (TRIG_W'(1) << TRIG_FRAC) : r[TRIG_W-1:0];
			return (v[CW-1] ^ neg) ? -signed'(rc) : signed'(rc);
		end
	endfunction

	logic [NST-1:0] v_s;
	logic [NST:0]   en;

	assign en[NST] = trig_ready;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = ~v_s[k] | en[k+1];
	end
	assign cmd.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0])
				v_s[0] <= cmd.valid;
			for (int k = 1; k < NST; k++)
				if (en[k])
					v_s[k] <= v_s[k-1];
		end
	end

	// fold into +-90 degrees; a half-turn shift is a flip of the top bit
	logic signed [ZW-1:0] ang;
	logic                 fold;
	logic signed [ZW-1:0] z_s1;
	logic                 flip_s1;
	axes_t                side_s1;

	assign ang  = {cmd.heading, {(ZW-ANGLE_BITS){1'b0}}};
	assign fold = (ang > QUARTER) || (ang < -QUARTER);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s1                  <= fold ? {~ang[ZW-1], ang[ZW-2:0]} : ang;
			flip_s1               <= fold;
			side_s1.stick_x       <= cmd.stick_x;
			side_s1.stick_y       <= cmd.stick_y;
			side_s1.trigger_right <= cmd.trigger_right;
			side_s1.trigger_left  <= cmd.trigger_left;
		end
	end

	// iteration stages
	logic signed [CW-1:0] x_s    [CORDIC_STAGES];
	logic signed [CW-1:0] y_s    [CORDIC_STAGES];
	logic signed [ZW-1:0] z_s    [CORDIC_STAGES];
	logic                 flip_s [CORDIC_STAGES];
	axes_t                side_s [CORDIC_STAGES];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
		logic signed [CW-1:0] xi, yi, xt, yt, dx, dy;
		logic signed [ZW-1:0] zi, zt;
		logic                 flip_i;
		axes_t                side_i;

		if (k == 0) begin : g_first
			assign xi     = CORDIC_GAIN;
			assign yi     = '0;
			assign zi     = z_s1;
			assign flip_i = flip_s1;
			assign side_i = side_s1;
		end else begin : g_next
			assign xi     = x_s[k-1];
			assign yi     = y_s[k-1];
			assign zi     = z_s[k-1];
			assign flip_i = flip_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			xt = xi;
			yt = yi;
			zt = zi;
			dx = '0;
			dy = '0;
			for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
				dx = div_pow2(xt, k * CORDIC_PER_STAGE + j);
				dy = div_pow2(yt, k * CORDIC_PER_STAGE + j);
				if (zt >= 0) begin
					xt = xt - dy;
					yt = yt + dx;
					zt = zt - ROT_TABLE[k * CORDIC_PER_STAGE + j];
				end else begin
					xt = xt + dy;
					yt = yt - dx;
					zt = zt + ROT_TABLE[k * CORDIC_PER_STAGE + j];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				x_s[k]    <= xt;
				y_s[k]    <= yt;
				z_s[k]    <= zt;
				flip_s[k] <= flip_i;
				side_s[k] <= side_i;
			end
		end
	end

	// round to Q1.15 and undo the fold
	trig_t trig_s12;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			trig_s12.cos_val <= to_q15(x_s[CORDIC_STAGES-1], flip_s[CORDIC_STAGES-1]);
			trig_s12.sin_val <= to_q15(y_s[CORDIC_STAGES-1], flip_s[CORDIC_STAGES-1]);
			trig_s12.axes    <= side_s[CORDIC_STAGES-1];
		end
	end

	assign trig_valid = v_s[NST-1];
	assign trig       = trig_s12;

endmodule

// ----- sv/fomw_mixer.sv -----
module fomw_mixer import fomw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               trig_valid,
	output logic               trig_ready,
	input  trig_t              trig,
	input  logic [GAIN_W-1:0]  speed_gain,
	input  logic [LIMIT_W-1:0] output_limit,
	fomw_drive_if.source       drive
);

	localparam int NST  = 6;
	localparam int PW   = AXIS_BITS + TRIG_W;        // axis * trig
	localparam int SW   = PW + 1;                    // rotated sum
	localparam int GPW  = SW + GAIN_W + 1;           // scaled by gain
	localparam int VSH  = AXIS_BITS - 2;
	localparam int VW   = GAIN_W + TRIG_W + 1;       // field velocity
	localparam int DW   = VW + 1;
	localparam int MPW  = DW + HW;                   // times 2^30/sqrt2
	localparam int MSH  = 16;
	localparam int MXW  = MPW - MSH;
	localparam int TDW  = AXIS_BITS + 1;
	localparam int TPW  = TDW + TFW;
	localparam int TSH  = 29 - AXIS_BITS;
	localparam int TQW  = TPW + TSH;
	localparam int SUMW = ((MXW > TQW) ? MXW : TQW) + 2;
	localparam int WSH  = 30;
	localparam int WW   = SUMW - WSH;

	localparam logic signed [GPW-1:0]  V_BIAS = signed'({{(GPW-VSH){1'b0}}, {VSH{1'b1}}});
	localparam logic signed [MPW-1:0]  M_BIAS = signed'({{(MPW-MSH){1'b0}}, {MSH{1'b1}}});
	localparam logic signed [SUMW-1:0] W_BIAS = signed'({{(SUMW-WSH){1'b0}}, {WSH{1'b1}}});

	logic [NST-1:0] v_s;
	logic [NST:0]   en;

	assign en[NST] = drive.ready;
	for (genvar k = 0; k < NST; k++) begin : g_en
		assign en[k] = ~v_s[k] | en[k+1];
	end
	assign trig_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0])
				v_s[0] <= trig_valid;
			for (int k = 1; k < NST; k++)
				if (en[k])
					v_s[k] <= v_s[k-1];
		end
	end

	// s1: axis by trig products, trigger difference
	logic signed [PW-1:0]  xc_s1, ys_s1, yc_s1, xs_s1;
	logic signed [TDW-1:0] tdiff_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xc_s1    <= PW'(trig.axes.stick_x) * PW'(trig.cos_val);
			ys_s1    <= PW'(trig.axes.stick_y) * PW'(trig.sin_val);
			yc_s1    <= PW'(trig.axes.stick_y) * PW'(trig.cos_val);
			xs_s1    <= PW'(trig.axes.stick_x) * PW'(trig.sin_val);
			tdiff_s1 <= TDW'(trig.axes.trigger_left) - TDW'(trig.axes.trigger_right);
		end
	end

	// s2: rotate, scale by gain; turn term
	logic signed [SW-1:0]     p_rot, q_rot;
	logic signed [GAIN_W:0]   gain_s;
	logic signed [GPW-1:0]    gx_s2, gy_s2;
	logic signed [TPW-1:0]    turn_s2;

	assign p_rot  = -SW'(xc_s1) - SW'(ys_s1);
	assign q_rot  = SW'(yc_s1) - SW'(xs_s1);
	assign gain_s = signed'({1'b0, speed_gain});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			gx_s2   <= GPW'(p_rot) * GPW'(gain_s);
			gy_s2   <= GPW'(q_rot) * GPW'(gain_s);
			turn_s2 <= TPW'(tdiff_s1) * TPW'(TURN_FACTOR);
		end
	end

	// s3: truncate to drive units, form the diagonal sums
	logic signed [GPW-1:0] gx_b, gy_b, vx_f, vy_f;
	logic signed [VW-1:0]  vx, vy;
	logic signed [DW-1:0]  dif_s3, sum_s3;
	logic signed [TPW-1:0] turn_s3;

	always_comb begin
		gx_b = gx_s2;
		gy_b = gy_s2;
		if (gx_s2[GPW-1])
			gx_b = gx_s2 + V_BIAS;
		if (gy_s2[GPW-1])
			gy_b = gy_s2 + V_BIAS;
		vx_f = gx_b >>> VSH;
		vy_f = gy_b >>> VSH;
		vx   = vx_f[VW-1:0];
		vy   = vy_f[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dif_s3  <= DW'(vy) - DW'(vx);
			sum_s3  <= DW'(vx) + DW'(vy);
			turn_s3 <= turn_s2;
		end
	end

	// s4: 45-degree factor
	logic signed [MPW-1:0] ma_s4, mb_s4;
	logic signed [TPW-1:0] turn_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ma_s4   <= MPW'(dif_s3) * MPW'(HALF_SQRT2);
			mb_s4   <= MPW'(sum_s3) * MPW'(HALF_SQRT2);
			turn_s4 <= turn_s3;
		end
	end

	// s5: truncate to Q30 and add the turn term; wheels 2 and 1 mirror 0 and 3
	logic signed [MPW-1:0]  ma_b, mb_b, ma_f, mb_f;
	logic signed [MXW-1:0]  mix_a, mix_b;
	logic signed [SUMW-1:0] turn_q;
	logic signed [SUMW-1:0] tot_s5 [4];

	always_comb begin
		ma_b = ma_s4;
		mb_b = mb_s4;
		if (ma_s4[MPW-1])
			ma_b = ma_s4 + M_BIAS;
		if (mb_s4[MPW-1])
			mb_b = mb_s4 + M_BIAS;
		ma_f   = ma_b >>> MSH;
		mb_f   = mb_b >>> MSH;
		mix_a  = ma_f[MXW-1:0];
		mix_b  = mb_f[MXW-1:0];
		turn_q = SUMW'(turn_s4) <<< TSH;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			tot_s5[0] <= turn_q + SUMW'(mix_a);
			tot_s5[1] <= turn_q - SUMW'(mix_b);
			tot_s5[2] <= turn_q - SUMW'(mix_a);
			tot_s5[3] <= turn_q + SUMW'(mix_b);
		end
	end

	// s6: truncate to integer, clamp
	logic signed [WW-1:0]      lim_w;
	logic signed [DRIVE_W-1:0] wheel_c [4];
	logic signed [DRIVE_W-1:0] wheel_s6 [4];

	assign lim_w = signed'(WW'(output_limit));

	for (genvar k = 0; k < 4; k++) begin : g_clamp
		logic signed [SUMW-1:0] tb, tf;
		logic signed [WW-1:0]   w;

		always_comb begin
			tb = tot_s5[k];
			if (tot_s5[k][SUMW-1])
				tb = tot_s5[k] + W_BIAS;
			tf = tb >>> WSH;
			w  = tf[WW-1:0];
			if (w > lim_w)
				w = lim_w;
			else if (w < -lim_w)
				w = -lim_w;
			wheel_c[k] = w[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5])
			for (int k = 0; k < 4; k++)
				wheel_s6[k] <= wheel_c[k];
	end

	assign drive.valid             = v_s[NST-1];
	assign drive.wheel_one_drive   = wheel_s6[0];
	assign drive.wheel_two_drive   = wheel_s6[1];
	assign drive.wheel_three_drive = wheel_s6[2];
	assign drive.wheel_four_drive  = wheel_s6[3];

endmodule

// ----- sv/field_oriented_omni_wheel_mixer.sv -----
// Field-oriented mixer for a four-wheel omni base (wheels at 45 degrees).
//
// cmd   : valid/ready word with two stick axes, two trigger axes (Q1.15) and
//         the heading as a binary angle. Accepted when valid and ready are high.
// drive : valid/ready word with the four saturated wheel drives.
// APB   : speed_gain at 0x0, output_limit at 0x4. pready is tied high; write
//         only while no word is in flight.
//
// Pipeline: 12 stages of sine/cosine (fold, 10 CORDIC stages of 3 iterations
// each, rounding), then 6 stages of rotate/scale/mix/clamp.
// Throughput: one word per cycle unless stalled by drive.ready (see below);
// each stage holds its own valid bit.
//
// Stall: when drive.ready is low the last stage holds its word; a stage moves
// whenever it is empty or the one after it moves, so bubbles close up and cmd
// keeps being taken until every stage is full. Nothing is dropped or repeated.
//
// Reset: all valid bits clear, speed_gain and output_limit return to 255.
module field_oriented_omni_wheel_mixer import fomw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fomw_cmd_if.sink    cmd,
	fomw_drive_if.source drive,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic {
		REG_SPEED_GAIN   = 1'b0,
		REG_OUTPUT_LIMIT = 1'b1
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(255);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(255);

	logic [GAIN_W-1:0]  speed_gain_q;
	logic [LIMIT_W-1:0] output_limit_q;
	logic               cfg_wr;
	reg_idx_t           reg_idx;

	// register file; byte lanes below the word boundary are ignored
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q   <= GAIN_RST;
			output_limit_q <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SPEED_GAIN:   speed_gain_q   <= pwdata[GAIN_W-1:0];
				REG_OUTPUT_LIMIT: output_limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SPEED_GAIN:   prdata = 32'(speed_gain_q);
			REG_OUTPUT_LIMIT: prdata = 32'(output_limit_q);
			default:          prdata = '0;
		endcase
	end

	// heading -> cos/sin, axes ride alongside
	logic  trig_valid;
	logic  trig_ready;
	trig_t trig;

	fomw_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.trig_valid (trig_valid),
		.trig_ready (trig_ready),
		.trig       (trig)
	);

	// field velocity, wheel mix, clamp
	fomw_mixer u_mixer (
		.clk          (clk),
		.arst_n       (arst_n),
		.trig_valid   (trig_valid),
		.trig_ready   (trig_ready),
		.trig         (trig),
		.speed_gain   (speed_gain_q),
		.output_limit (output_limit_q),
		.drive        (drive)
	);

	// checks
	logic signed [DRIVE_W-1:0] lim_chk;
	logic                      in_limit;

	assign lim_chk  = signed'(DRIVE_W'(output_limit_q));
	assign in_limit =
		(drive.wheel_one_drive   <= lim_chk) && (drive.wheel_one_drive   >= -lim_chk) &&
		(drive.wheel_two_drive   <= lim_chk) && (drive.wheel_two_drive   >= -lim_chk) &&
		(drive.wheel_three_drive <= lim_chk) && (drive.wheel_three_drive >= -lim_chk) &&
		(drive.wheel_four_drive  <= lim_chk) && (drive.wheel_four_drive  >= -lim_chk);

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> in_limit)
		else $error("wheel drive outside output limit");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(drive.ready || !drive.valid) |-> cmd.ready)
		else $error("cmd stalled while output stage can move");

	a_mirror_turnless: assert property (@(posedge clk) disable iff (!arst_n)
		(drive.valid && (drive.wheel_one_drive == -drive.wheel_three_drive)) |->
		(drive.wheel_one_drive + drive.wheel_three_drive == 0))
		else $error("mirror wheels inconsistent");

endmodule
